// ===== rtl/core/hwfm_pkg.sv =====
package hwfm_pkg;

  localparam int MAG_W    = 24;
  localparam int RAD_W    = 2 * MAG_W;
  localparam int DATA_W   = 24;
  localparam int TW_W     = 18;
  localparam int SAMPLE_W = 16;
  localparam int HANN_W   = 17;
  localparam int BIN_W    = 6;
  localparam int CNT_W    = 4;
  localparam int SEL_W    = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_SELECT = 2'd1;

  localparam logic [CNT_W-1:0] CNT_RESET = 4'd2;
  localparam logic [CNT_W-1:0] CNT_MAX   = 4'd8;

  localparam longint Q30_ONE     = 64'sd1 << 30;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam longint COS_D12 = Q30_ONE * 132;
  localparam longint COS_D10 = Q30_ONE * 90;
  localparam longint COS_D8  = Q30_ONE * 56;
  localparam longint COS_D6  = Q30_ONE * 30;
  localparam longint COS_D4  = Q30_ONE * 12;
  localparam longint COS_D2  = Q30_ONE * 2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PAD,
    ST_BF_RD,
    ST_BF_MUL,
    ST_BF_ADD,
    ST_BF_WA,
    ST_BF_WB,
    ST_MAG_RD,
    ST_MAG_SQ,
    ST_MAG_SUM,
    ST_MAG_WAIT
  } hwfm_state_t;

  // Fixed-point cosine of a 32-bit turn fraction, Q16 result.
  // Elaboration only: builds the window and twiddle tables.
  function automatic logic signed [TW_W-1:0] cos_q16(input logic [31:0] phase);
    logic [1:0] quad;
    longint     frac;
    longint     x;
    longint     x2;
    longint     t;
    longint     mag;
    quad = phase[31:30];
    frac = longint'({34'd0, phase[29:0]});
    if (quad[0]) frac = Q30_ONE - frac;
    x  = (frac * HALF_PI_Q30) >>> 30;
    x2 = (x * x) >>> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - (x2 * t) / COS_D12;
    t  = Q30_ONE - (x2 * t) / COS_D10;
    t  = Q30_ONE - (x2 * t) / COS_D8;
    t  = Q30_ONE - (x2 * t) / COS_D6;
    t  = Q30_ONE - (x2 * t) / COS_D4;
    t  = Q30_ONE - (x2 * t) / COS_D2;
    mag = (t < 0) ? -t : t;
    mag = (mag + 64'sd8192) >>> 14;
    if (quad == 2'd1 || quad == 2'd2) return -TW_W'(mag);
    return TW_W'(mag);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat24(input logic signed [DATA_W+3:0] v);
    if (v > (DATA_W+4)'(2**(DATA_W-1) - 1)) return {1'b0, {(DATA_W-1){1'b1}}};
    if (v < -(DATA_W+4)'(2**(DATA_W-1)))    return {1'b1, {(DATA_W-1){1'b0}}};
    return v[DATA_W-1:0];
  endfunction

endpackage

// ===== rtl/core/hwfm_isqrt.sv =====
module hwfm_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [hwfm_pkg::RAD_W-1:0] radicand,
  output logic                       done,
  output logic [hwfm_pkg::MAG_W-1:0] root
);
  import hwfm_pkg::*;

  localparam int REM_W  = MAG_W + 3;
  localparam int ITER_W = $clog2(MAG_W);

  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [MAG_W-1:0]  root_r;
  logic [ITER_W-1:0] iter_r;
  logic              run_r;
  logic              done_r;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;

  // one result bit per cycle, restoring
  assign rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        iter_r <= '0;
      end else if (run_r) begin
        iter_r <= iter_r + 1'b1;
        if (iter_r == ITER_W'(MAG_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (run_r) begin
      rad_r <= {rad_r[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[MAG_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[MAG_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== rtl/core/hann_windowed_fft_magnitude_core.sv =====
// Hann-windowed FFT magnitude of one channel of an interleaved Q1.15
// stream. An item (one interleaved sample) is taken when start is high and
// busy is low. Samples of the selected channel are windowed and stored in
// bit-reversed order in a frame memory; each item is loaded through the states IDLE and LOAD.
// When FFT_POINTS samples are held, or end_of_audio arrives with at least
// one held, the frame is zero padded (one entry per cycle), transformed in
// place with radix-2 butterflies (FFT_POINTS/2*log2 of them, each through
// the states read, multiply, add, write A and write B, as the single memory
// write port allows), and FFT_POINTS/2 magnitudes are emitted, each after
// read, square, sum and bit-serial square root. Busy is high while an item
// is loaded and while a frame is padded, transformed and read out.
// Each result is shown for exactly one cycle under
// out_valid; the receiver cannot stall it. Configuration writes are always
// taken (cfg_ready is tied high) and should be made while busy is low.
module hann_windowed_fft_magnitude_core #(
  parameter int FFT_POINTS = 128
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [hwfm_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                in_end_of_audio,
  output logic                                out_valid,
  output logic [hwfm_pkg::MAG_W-1:0]          out_magnitude,
  output logic [hwfm_pkg::BIN_W-1:0]          out_bin_index,
  output logic                                out_last_bin,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hwfm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hwfm_pkg::CNT_W-1:0]          cfg_data
);
  import hwfm_pkg::*;

  localparam int AW     = $clog2(FFT_POINTS);
  localparam int HALF   = FFT_POINTS / 2;
  localparam int SW     = $clog2(AW);
  localparam int WORD_W = 2 * DATA_W;

  // ---------------------------------------------------------------- tables
  logic [HANN_W-1:0]        hann_rom [FFT_POINTS];
  logic signed [TW_W-1:0]   tw_re_rom [HALF];
  logic signed [TW_W-1:0]   tw_im_rom [HALF];

  for (genvar g = 0; g < FFT_POINTS; g++) begin : g_hann
    localparam longint      HPH = (longint'(g) << 32) / (FFT_POINTS - 1);
    localparam logic [31:0] HP  = HPH[31:0];
    // w = (1 - cos) / 2 in unsigned Q1.16
    assign hann_rom[g] = HANN_W'((19'sd65536 - 19'(cos_q16(HP))) >>> 1);
  end

  for (genvar g = 0; g < HALF; g++) begin : g_tw
    localparam logic [31:0] TP = 32'(longint'(g) << (32 - AW));
    assign tw_re_rom[g] = cos_q16(TP);
    assign tw_im_rom[g] = -cos_q16(TP - QUARTER_TURN);
  end

  function automatic logic [AW-1:0] bitrev(input logic [AW-1:0] a);
    logic [AW-1:0] r;
    for (int i = 0; i < AW; i++) r[i] = a[AW-1-i];
    return r;
  endfunction

  // ---------------------------------------------------------------- state
  hwfm_state_t state_r, state_nxt;

  logic [CNT_W-1:0]  cnt_r;
  logic [SEL_W-1:0]  sel_r;
  logic [SEL_W-1:0]  pos_r;
  logic [AW:0]       kept_r;
  logic              end_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [HANN_W-1:0] hann_r;
  logic [SW-1:0]     stage_r;
  logic [AW-2:0]     bfly_r;
  logic [AW-2:0]     bin_r;

  // frame memory: {re, im}, Q8.16 each; entries hold bit-reversed order
  logic [WORD_W-1:0] frame_mem [FFT_POINTS];
  logic [WORD_W-1:0] rd_a_r, rd_b_r;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_ra, mem_rb;
  logic [WORD_W-1:0] mem_wdata;

  // butterfly datapath
  logic signed [TW_W-1:0]          wr_r, wi_r;
  logic signed [DATA_W+TW_W-1:0]   p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic [WORD_W-1:0]               a_r;
  logic [WORD_W-1:0]               na_r, nb_r;

  // magnitude datapath
  logic [RAD_W-2:0]  sq_re_r, sq_im_r;
  logic              sq_start;
  logic              sq_done;
  logic [MAG_W-1:0]  sq_root;

  logic              out_valid_r;
  logic [MAG_W-1:0]  out_mag_r;
  logic [BIN_W-1:0]  out_bin_r;
  logic              out_last_r;

  // ---------------------------------------------------------------- load math
  logic [CNT_W-1:0]  cc;
  logic              keep;
  logic [AW:0]       kept_inc;
  logic [CNT_W-1:0]  pos_p1;
  logic [SEL_W-1:0]  pos_adv;
  logic              go_fft;
  logic signed [SAMPLE_W+HANN_W:0] win_prod;
  logic signed [DATA_W-1:0]        win_val;

  always_comb begin
    // count 0 acts as 1, above 8 acts as 8
    if (cnt_r == '0)         cc = CNT_W'(1);
    else if (cnt_r > CNT_MAX) cc = CNT_MAX;
    else                     cc = cnt_r;
  end

  assign keep     = (pos_r == sel_r) && (kept_r < (AW+1)'(FFT_POINTS));
  assign kept_inc = kept_r + (AW+1)'(keep);
  assign pos_p1   = CNT_W'(pos_r) + CNT_W'(1);
  assign pos_adv  = (pos_p1 >= cc) ? '0 : pos_p1[SEL_W-1:0];
  assign go_fft   = (kept_inc == (AW+1)'(FFT_POINTS)) || (end_r && (kept_inc != '0));
  assign win_prod = sample_r * $signed({1'b0, hann_r});
  assign win_val  = DATA_W'(win_prod >>> (SAMPLE_W - 1));

  // ---------------------------------------------------------------- fft addressing
  logic [AW-2:0] lo_mask;
  logic [AW-1:0] addr_a, addr_b;
  logic [AW-2:0] tw_idx;

  always_comb begin
    lo_mask = ~({(AW-1){1'b1}} << stage_r);
    addr_a  = {bfly_r & ~lo_mask, 1'b0} | {1'b0, bfly_r & lo_mask};
    addr_b  = addr_a | (AW'(1) << stage_r);
    tw_idx  = (bfly_r & lo_mask) << (SW'(AW - 1) - stage_r);
  end

  // butterfly add stage
  logic signed [DATA_W+TW_W:0] t_re_full, t_im_full;
  logic signed [DATA_W+3:0]    t_re, t_im;
  logic signed [DATA_W-1:0]    a_re, a_im;

  assign t_re_full = (DATA_W+TW_W+1)'(p_rr_r) - (DATA_W+TW_W+1)'(p_ii_r);
  assign t_im_full = (DATA_W+TW_W+1)'(p_ri_r) + (DATA_W+TW_W+1)'(p_ir_r);
  assign t_re      = (DATA_W+4)'(t_re_full >>> 16);
  assign t_im      = (DATA_W+4)'(t_im_full >>> 16);
  assign a_re      = a_r[WORD_W-1 -: DATA_W];
  assign a_im      = a_r[DATA_W-1:0];

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (start) state_nxt = ST_LOAD;
      ST_LOAD:     state_nxt = go_fft ? ST_PAD : ST_IDLE;
      ST_PAD:      if (kept_r[AW]) state_nxt = ST_BF_RD;
      ST_BF_RD:    state_nxt = ST_BF_MUL;
      ST_BF_MUL:   state_nxt = ST_BF_ADD;
      ST_BF_ADD:   state_nxt = ST_BF_WA;
      ST_BF_WA:    state_nxt = ST_BF_WB;
      ST_BF_WB: begin
        if (bfly_r == (AW-1)'(HALF - 1) && stage_r == SW'(AW - 1)) state_nxt = ST_MAG_RD;
        else                                                      state_nxt = ST_BF_RD;
      end
      ST_MAG_RD:   state_nxt = ST_MAG_SQ;
      ST_MAG_SQ:   state_nxt = ST_MAG_SUM;
      ST_MAG_SUM:  state_nxt = ST_MAG_WAIT;
      ST_MAG_WAIT: begin
        if (sq_done) state_nxt = (bin_r == (AW-1)'(HALF - 1)) ? ST_IDLE : ST_MAG_RD;
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs of the FSM
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_a;
    mem_wdata = na_r;
    mem_ra    = addr_a;
    mem_rb    = addr_b;
    sq_start  = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        mem_we    = keep;
        mem_waddr = bitrev(kept_r[AW-1:0]);
        mem_wdata = {win_val, {DATA_W{1'b0}}};
      end
      ST_PAD: begin
        mem_we    = !kept_r[AW];
        mem_waddr = bitrev(kept_r[AW-1:0]);
        mem_wdata = '0;
      end
      ST_BF_WA: begin
        mem_we    = 1'b1;
        mem_waddr = addr_a;
        mem_wdata = na_r;
      end
      ST_BF_WB: begin
        mem_we    = 1'b1;
        mem_waddr = addr_b;
        mem_wdata = nb_r;
      end
      ST_MAG_RD:  mem_ra   = {1'b0, bin_r};
      ST_MAG_SUM: sq_start = 1'b1;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- memory
  always_ff @(posedge clk) begin
    if (mem_we) frame_mem[mem_waddr] <= mem_wdata;
    rd_a_r <= frame_mem[mem_ra];
    rd_b_r <= frame_mem[mem_rb];
  end

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= CNT_RESET;
      sel_r       <= '0;
      pos_r       <= '0;
      kept_r      <= '0;
      end_r       <= 1'b0;
      stage_r     <= '0;
      bfly_r      <= '0;
      bin_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;

      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_CHANNEL_COUNT:  cnt_r <= cfg_data;
          CFG_CHANNEL_SELECT: sel_r <= cfg_data[SEL_W-1:0];
          default: ;
        endcase
      end

      unique case (state_r)
        ST_IDLE: if (start) end_r <= in_end_of_audio;
        ST_LOAD: begin
          if (go_fft) begin
            kept_r  <= kept_inc;
            pos_r   <= pos_adv;
            stage_r <= '0;
            bfly_r  <= '0;
            bin_r   <= '0;
          end else if (end_r) begin
            kept_r <= '0;
            pos_r  <= '0;
          end else begin
            kept_r <= kept_inc;
            pos_r  <= pos_adv;
          end
        end
        ST_PAD: if (!kept_r[AW]) kept_r <= kept_r + 1'b1;
        ST_BF_WB: begin
          bfly_r <= bfly_r + 1'b1;
          if (bfly_r == (AW-1)'(HALF - 1)) stage_r <= stage_r + 1'b1;
        end
        ST_MAG_WAIT: begin
          if (sq_done) begin
            out_valid_r <= 1'b1;
            bin_r       <= bin_r + 1'b1;
            if (bin_r == (AW-1)'(HALF - 1)) begin
              kept_r <= '0;
              if (end_r) pos_r <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath registers
  always_ff @(posedge clk) begin
    if (start && state_r == ST_IDLE) sample_r <= in_sample;
    if (state_r == ST_IDLE) hann_r <= hann_rom[kept_r[AW-1:0]];

    if (state_r == ST_BF_RD) begin
      wr_r <= tw_re_rom[tw_idx];
      wi_r <= tw_im_rom[tw_idx];
    end
    if (state_r == ST_BF_MUL) begin
      a_r    <= rd_a_r;
      p_rr_r <= wr_r * $signed(rd_b_r[WORD_W-1 -: DATA_W]);
      p_ii_r <= wi_r * $signed(rd_b_r[DATA_W-1:0]);
      p_ri_r <= wr_r * $signed(rd_b_r[DATA_W-1:0]);
      p_ir_r <= wi_r * $signed(rd_b_r[WORD_W-1 -: DATA_W]);
    end
    if (state_r == ST_BF_ADD) begin
      na_r <= {sat24((DATA_W+4)'(a_re) + t_re), sat24((DATA_W+4)'(a_im) + t_im)};
      nb_r <= {sat24((DATA_W+4)'(a_re) - t_re), sat24((DATA_W+4)'(a_im) - t_im)};
    end

    if (state_r == ST_MAG_SQ) begin
      sq_re_r <= (RAD_W-1)'($signed(rd_a_r[WORD_W-1 -: DATA_W]) *
                            $signed(rd_a_r[WORD_W-1 -: DATA_W]));
      sq_im_r <= (RAD_W-1)'($signed(rd_a_r[DATA_W-1:0]) * $signed(rd_a_r[DATA_W-1:0]));
    end

    if (state_r == ST_MAG_WAIT && sq_done) begin
      out_mag_r  <= sq_root;
      out_bin_r  <= BIN_W'(bin_r);
      out_last_r <= (bin_r == (AW-1)'(HALF - 1));
    end
  end

  // sum of squares never exceeds 2^47, so the root always fits 24 bits
  hwfm_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand ({1'b0, sq_re_r} + {1'b0, sq_im_r}),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign busy          = (state_r != ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_magnitude = out_mag_r;
  assign out_bin_index = out_bin_r;
  assign out_last_bin  = out_last_r;

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_bin) |=> !out_valid)
    else $error("result after last bin");

  a_kept_range: assert property (@(posedge clk) disable iff (!rst_n)
    kept_r <= (AW+1)'(FFT_POINTS))
    else $error("kept count beyond frame size");

  a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !$past(busy)) |-> !out_valid)
    else $error("result while idle");
`endif

endmodule
